### hdl/b64u_pkg.sv
package b64u_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned GROUP_W   = 3 * BYTE_W;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
    localparam logic [7:0] DASH_CHAR  = 8'h2D;  // '-'
    localparam logic [7:0] UNDER_CHAR = 8'h5F;  // '_'

    // Number of '=' characters that close a group.
    typedef enum logic [1:0] {
        PAD_NONE = 2'd0,
        PAD_ONE  = 2'd1,
        PAD_TWO  = 2'd2
    } t_pad;

    // One group of up to three bytes, first byte in the top bits.
    typedef struct packed {
        logic [GROUP_W-1:0] data;
        t_pad               pad;
        logic               last;
    } t_group;

    // Front-to-queue push.
    typedef struct packed {
        logic   valid;
        t_group grp;
    } t_push;

    function automatic logic [7:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        c = 8'h00;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v - 6'd26};
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v - 6'd52};
        end else if (v == 6'd62) begin
            c = DASH_CHAR;
        end else begin
            c = UNDER_CHAR;
        end
        return c;
    endfunction

endpackage

### hdl/base64url_stream_encoder_core.sv
// Channel  | Dir | Beat content                          | Handshake
// ---------+-----+---------------------------------------+-------------------------------
// s_axis   | in  | tdata[7:0] raw byte, tlast final byte | tvalid & tready
// m_axis   | out | tdata[7:0] ASCII char, tlast end text | tvalid & tready
//
// The front accepts one byte per cycle while the two-entry group queue has room;
// a byte that closes a group (third byte, or the final byte) pushes one group.
// The back emits one character per cycle, while the sink is ready, from a
// registered output stage; each group yields four characters, so sustained
// rate is set by this serializer.
// The closing byte's group is written into the queue, and the first character
// is then loaded from the queue head into the registered output stage.
// Synchronous active-low reset clears held count, queue pointers, and output valid.
// Either side may stall at any time; the queue decouples the two.
module base64url_stream_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // is_final
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_char
    output logic       m_axis_tlast    // end_of_text
);
    import b64u_pkg::*;

    t_push  front_push;
    t_group q_head;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    logic   in_beat;

    // Hold off input whenever the queue could not take a group.
    assign s_axis_tready = !q_full;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    b64u_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_beat),
        .i_byte   (s_axis_tdata),
        .i_final  (s_axis_tlast),
        .o_push   (front_push)
    );

    b64u_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (front_push),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_valid  (q_valid),
        .o_head   (q_head)
    );

    b64u_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_char    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

endmodule

### hdl/b64u_front.sv
module b64u_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_byte,
    input  logic               i_final,
    output b64u_pkg::t_push    o_push
);
    import b64u_pkg::*;

    logic [7:0] r_held0, n_held0;
    logic [7:0] r_held1, n_held1;
    logic [1:0] r_cnt, n_cnt;

    always_comb begin
        n_held0      = r_held0;
        n_held1      = r_held1;
        n_cnt        = r_cnt;
        o_push.valid = 1'b0;
        o_push.grp   = '{data: '0, pad: PAD_NONE, last: 1'b0};
        if (i_accept) begin
            if (r_cnt >= 2'd2) begin
                // complete group: four characters
                o_push.valid = 1'b1;
                o_push.grp   = '{data: {r_held0, r_held1, i_byte}, pad: PAD_NONE,
                                 last: i_final};
                n_cnt        = 2'd0;
            end else if (!i_final) begin
                if (r_cnt == 2'd0) begin
                    n_held0 = i_byte;
                end else begin
                    n_held1 = i_byte;
                end
                n_cnt = r_cnt + 2'd1;
            end else begin
                o_push.valid = 1'b1;
                if (r_cnt == 2'd0) begin
                    o_push.grp = '{data: {i_byte, 16'h0000}, pad: PAD_TWO, last: 1'b1};
                end else begin
                    o_push.grp = '{data: {r_held0, i_byte, 8'h00}, pad: PAD_ONE,
                                   last: 1'b1};
                end
                n_cnt = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_held0 <= n_held0;
        r_held1 <= n_held1;
    end

endmodule

### hdl/b64u_queue.sv
module b64u_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  b64u_pkg::t_push    i_push,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output b64u_pkg::t_group   o_head
);
    import b64u_pkg::*;

    t_group             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_cnt, n_cnt;
    logic               push_en;
    logic               pop_en;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];
    assign push_en = i_push.valid && !o_full;
    assign pop_en  = i_pop && o_valid;

    always_comb begin
        n_wr  = push_en ? Q_PTR_W'(r_wr + 1'b1) : r_wr;
        n_rd  = pop_en  ? Q_PTR_W'(r_rd + 1'b1) : r_rd;
        n_cnt = r_cnt + Q_CNT_W'(push_en) - Q_CNT_W'(pop_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (push_en) begin
            r_mem[r_wr] <= i_push.grp;
        end
    end

endmodule

### hdl/b64u_back.sv
module b64u_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  b64u_pkg::t_group   i_q_head,
    output logic               o_q_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_char,
    output logic               o_last
);
    import b64u_pkg::*;

    logic [1:0] r_idx, n_idx;
    logic       r_valid, n_valid;
    logic [7:0] r_char, n_char;
    logic       r_last, n_last;
    logic       issue;
    logic [5:0] sextet;
    logic       is_pad;

    assign issue   = i_q_valid && (!r_valid || i_ready);
    assign o_q_pop = issue && (r_idx == 2'd3);

    always_comb begin
        case (r_idx)
            2'd0:    sextet = i_q_head.data[23:18];
            2'd1:    sextet = i_q_head.data[17:12];
            2'd2:    sextet = i_q_head.data[11:6];
            2'd3:    sextet = i_q_head.data[5:0];
            default: sextet = '0;
        endcase
        case (i_q_head.pad)
            PAD_ONE: is_pad = (r_idx == 2'd3);
            PAD_TWO: is_pad = (r_idx >= 2'd2);
            default: is_pad = 1'b0;
        endcase
    end

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid;
        n_char  = r_char;
        n_last  = r_last;
        if (issue) begin
            n_idx   = r_idx + 2'd1;
            n_valid = 1'b1;
            n_char  = is_pad ? PAD_CHAR : sextet_char(sextet);
            n_last  = i_q_head.last && (r_idx == 2'd3);
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

### hdl/b64u_checker.sv
module b64u_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);

    // Stalled output beat holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed under stall");

    // Reset leaves no output beat pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Every character is from the URL-safe alphabet or a pad.
    a_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata >= 8'h41 && m_axis_tdata <= 8'h5A) ||
            (m_axis_tdata >= 8'h61 && m_axis_tdata <= 8'h7A) ||
            (m_axis_tdata >= 8'h30 && m_axis_tdata <= 8'h39) ||
            m_axis_tdata == 8'h2D || m_axis_tdata == 8'h5F || m_axis_tdata == 8'h3D)
        else $error("character outside alphabet");

    // A pad that is not the last character is followed by another pad.
    a_pad_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tdata == 8'h3D && !m_axis_tlast
            ##1 m_axis_tvalid |-> m_axis_tdata == 8'h3D)
        else $error("pad not followed by pad");

endmodule

bind base64url_stream_encoder_core b64u_checker u_b64u_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import b64u_pkg::*;

    localparam int unsigned RAND_BYTES    = 145;
    localparam int unsigned IDLE_PCT      = 34;
    localparam int unsigned STALL_AT_BYTE = 40;   // start the long sink stall here
    localparam int unsigned STALL_CYCLES  = 120;
    localparam int unsigned CALM_FROM     = 90;   // no idling on either side
    localparam int unsigned CALM_TO       = 140;  //   while this many bytes are in
    localparam int unsigned DRAIN_CYCLES  = 20;
    localparam int unsigned WATCHDOG_MAX  = 1000;

    typedef struct {
        logic [7:0] data;
        logic       fin;
    } t_raw_byte;

    typedef struct {
        logic [7:0] ch;
        logic       eot;
    } t_enc_char;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic       s_axis_tlast = 1'b0;    // is_final
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] out_char
    logic       m_axis_tlast;           // end_of_text

    t_raw_byte   byte_queue[$];   // bytes waiting to be offered
    t_enc_char   char_expect[$];  // characters still owed by the encoder

    // Encoder state as predicted from accepted bytes.
    logic [7:0]  grp_byte[2] = '{8'h00, 8'h00};
    logic [1:0]  grp_fill = 2'd0;

    int unsigned bytes_taken = 0;
    int unsigned err_count = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left = 0;
    bit          stall_done = 1'b0;
    logic        calm;

    base64url_stream_encoder_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    assign calm = (bytes_taken >= CALM_FROM) && (bytes_taken < CALM_TO);

    function automatic logic [7:0] url_char(input logic [5:0] v);
        if (v < 6'd26) return 8'h41 + 8'(v);
        if (v < 6'd52) return 8'h61 + 8'(v - 6'd26);
        if (v < 6'd62) return 8'h30 + 8'(v - 6'd52);
        if (v == 6'd62) return DASH_CHAR;
        return UNDER_CHAR;
    endfunction

    task automatic owe_char(input logic [7:0] ch, input logic eot);
        t_enc_char c;
        c.ch  = ch;
        c.eot = eot;
        char_expect.push_back(c);
    endtask

    // Advance the predicted encoder by one accepted byte; owe four characters
    // whenever a group closes.
    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [1:0] fill;
        logic [7:0] b0;
        logic [7:0] b1;
        fill = (grp_fill > 2'd2) ? 2'd2 : grp_fill;
        b0   = grp_byte[0];
        b1   = grp_byte[1];
        if (fill == 2'd2) begin
            owe_char(url_char(b0[7:2]), 1'b0);
            owe_char(url_char({b0[1:0], b1[7:4]}), 1'b0);
            owe_char(url_char({b1[3:0], b[7:6]}), 1'b0);
            owe_char(url_char(b[5:0]), fin);
            grp_fill = 2'd0;
        end else if (!fin) begin
            grp_byte[fill] = b;
            grp_fill = fill + 2'd1;
        end else begin
            if (fill == 2'd0) begin
                // lone byte: two characters and a double pad
                owe_char(url_char(b[7:2]), 1'b0);
                owe_char(url_char({b[1:0], 4'h0}), 1'b0);
                owe_char(PAD_CHAR, 1'b0);
            end else begin
                owe_char(url_char(b0[7:2]), 1'b0);
                owe_char(url_char({b0[1:0], b[7:4]}), 1'b0);
                owe_char(url_char({b[3:0], 2'b00}), 1'b0);
            end
            owe_char(PAD_CHAR, 1'b1);
            grp_fill = 2'd0;
        end
    endtask

    task automatic report_err(input string what);
        $display("tb_top: mismatch at %0t: %s", $time, what);
        err_count++;
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        t_raw_byte r;
        r.data = b;
        r.fin  = fin;
        byte_queue.push_back(r);
    endtask

    // Source side: hold a beat until taken, then offer the next one or idle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                s_axis_tdata  <= byte_queue[0].data;
                s_axis_tlast  <= byte_queue[0].fin;
                s_axis_tvalid <= 1'b1;
                void'(byte_queue.pop_front());
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sink side: random back-pressure, plus one long stall so the queue fills
    // and the encoder has to drop tready on its input.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!stall_done && bytes_taken >= STALL_AT_BYTE) begin
            stall_left    <= STALL_CYCLES;
            stall_done    <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Predict on every input beat, check every output beat.
    always @(posedge i_clk) begin
        t_enc_char want;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            encode_byte(s_axis_tdata, s_axis_tlast);
            bytes_taken <= bytes_taken + 1;
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (char_expect.size() == 0) begin
                report_err($sformatf("unexpected char 0x%02h tlast %0b",
                                     m_axis_tdata, m_axis_tlast));
            end else begin
                want = char_expect.pop_front();
                if (m_axis_tdata !== want.ch)
                    report_err($sformatf("char 0x%02h, want 0x%02h",
                                         m_axis_tdata, want.ch));
                if (m_axis_tlast !== want.eot)
                    report_err($sformatf("tlast %0b, want %0b on char 0x%02h",
                                         m_axis_tlast, want.eot, want.ch));
            end
        end
    end

    // Watchdog: end the run if neither side moves for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned len;

        // Directed messages: lone bytes at both extremes, two-byte and full
        // groups, all-dash and all-underscore groups, a full group followed
        // by a one- and a two-byte tail.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hFB, 1'b0); queue_byte(8'hFF, 1'b1);
        queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'h00, 1'b1);
        queue_byte(8'hFB, 1'b0); queue_byte(8'hEF, 1'b0); queue_byte(8'hBE, 1'b1);
        queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'hFF, 1'b1);
        queue_byte(8'h4D, 1'b0); queue_byte(8'h61, 1'b0); queue_byte(8'h6E, 1'b0);
        queue_byte(8'h80, 1'b1);
        queue_byte(8'h01, 1'b0); queue_byte(8'h7F, 1'b0); queue_byte(8'h80, 1'b0);
        queue_byte(8'hFE, 1'b0); queue_byte(8'h55, 1'b1);

        // Random messages, mostly short, now and then a long one.
        n = 0;
        while (n < RAND_BYTES) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 7);
            for (int unsigned k = 0; k < len; k++)
                queue_byte(8'($urandom_range(255)), k == len - 1);
            n += len;
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (byte_queue.size() != 0 || s_axis_tvalid || char_expect.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

### base64url_stream_encoder_core.f
hdl/b64u_pkg.sv
hdl/b64u_front.sv
hdl/b64u_queue.sv
hdl/b64u_back.sv
hdl/base64url_stream_encoder_core.sv
hdl/b64u_checker.sv
tb/tb_top.sv
